### rtl/core/ep2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar shared definitions
// Types, calendar constants and the month length table used by the front,
// queue and back parts of the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package ep2cal_pkg;

    // Width of the whole-day count (the largest input gives 49710 days).
    localparam int unsigned DAYS_W = 16;

    // Divisors of the time-of-day split.
    localparam logic [5:0] SEC_PER_MIN  = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR = 6'd60;
    localparam logic [5:0] HOUR_PER_DAY = 6'd24;

    // Year lengths and the leap February.
    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;
    localparam logic [4:0] DAYS_FEB_LEAP    = 5'd29;
    localparam logic [4:0] DAYS_FEB_COMMON  = 5'd28;
    localparam logic [4:0] DAYS_LONG_MONTH  = 5'd31;
    localparam logic [4:0] DAYS_SHORT_MONTH = 5'd30;

    // Residues of the epoch year 1970 modulo 4, 100 and 400.
    localparam logic [1:0] EPOCH_MOD4   = 2'd2;
    localparam logic [6:0] EPOCH_MOD100 = 7'd70;
    localparam logic [8:0] EPOCH_MOD400 = 9'd370;
    localparam logic [6:0] MOD100_LAST  = 7'd99;
    localparam logic [8:0] MOD400_LAST  = 9'd399;

    // Month indexes, counted from zero.
    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_MAY = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_JUL = 4'd6;
    localparam logic [3:0] MON_AUG = 4'd7;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_OCT = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    // Time of day and whole days of one request, handed from front to back.
    typedef struct packed {
        logic [5:0]        sec;
        logic [5:0]        min;
        logic [4:0]        hr;
        logic [DAYS_W-1:0] days;
    } tod_item_t;

    // Fill status of the queue between front and back.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Days in a month, with February depending on the leap flag.
    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                MON_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB_COMMON;
                MON_APR: len = DAYS_SHORT_MONTH;
                MON_JUN: len = DAYS_SHORT_MONTH;
                MON_SEP: len = DAYS_SHORT_MONTH;
                MON_NOV: len = DAYS_SHORT_MONTH;
                default: len = DAYS_LONG_MONTH;
            endcase
            return len;
        end
    endfunction

endpackage

### rtl/core/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch seconds to calendar converter
// Turns an unsigned count of seconds since 1970-01-01 00:00:00 into second,
// minute, hour, day of month, month and year of century.
//
// Usage: present epoch_seconds with in_valid; the request is taken when
// in_ready is high. Each request gives one result on the out channel, held
// with out_valid until out_ready takes it.
// For each request the front end takes these steps: the accept step, three
// divisions (by 60, 60 and 24) of one multiply step and one correction
// step each on a shared reciprocal multiplier, and the push into the queue.
// The back end then subtracts one year per cycle from 1970 (up to 136
// years) and one month per cycle (up to 11 months). Front and back overlap
// through a two-entry queue, so the front end can take a new request while
// the back end still works on an earlier one. A stalled receiver holds the
// output register; the back end then waits, the queue fills and in_ready
// drops. Reset empties the queue and the output register; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second_of_minute,
    output logic [5:0]  minute_of_hour,
    output logic [4:0]  hour_of_day,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month_of_year,
    output logic [6:0]  year_of_century
);
    import ep2cal_pkg::*;

    logic      push_valid;
    tod_item_t push_item;
    logic      pop_req;
    tod_item_t pop_item;
    q_status_t q_status;

    // Front end: request intake and time-of-day split.
    ep2cal_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .epoch_seconds (epoch_seconds),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .q_status      (q_status)
    );

    // Queue between front and back.
    ep2cal_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .pop_req    (pop_req),
        .pop_item   (pop_item),
        .q_status   (q_status)
    );

    // Back end: year and month subtraction and output register.
    ep2cal_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_req          (pop_req),
        .pop_item         (pop_item),
        .q_status         (q_status),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .year_of_century  (year_of_century)
    );

`ifndef SYNTHESIS
    // The queue can never report full and empty at once.
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty together");

    // A pending front-end item is only left waiting while the queue is full.
    a_push_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !q_status.full) |=> !push_valid)
        else $error("front end kept an item the queue could take");

    // A delivered date stays inside the calendar ranges.
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month_of_year >= 4'd1) && (month_of_year <= 4'd12)
                      && (day_of_month >= 5'd1) && (year_of_century <= 7'd99))
        else $error("date out of range");

    // A delivered time of day stays inside its ranges.
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (second_of_minute <= 6'd59) && (minute_of_hour <= 6'd59)
                      && (hour_of_day <= 5'd23))
        else $error("time of day out of range");
`endif

endmodule

### rtl/core/ep2cal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar front end
// Accepts a request and splits the seconds count into second, minute, hour
// and whole days with one shared reciprocal multiplier: each division takes
// one multiply step and one remainder-and-correction step.
// ----------------------------------------------------------------------------
module ep2cal_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [31:0]            epoch_seconds,
    output logic                   push_valid,
    output ep2cal_pkg::tod_item_t  push_item,
    input  ep2cal_pkg::q_status_t  q_status
);
    import ep2cal_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_FIX  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam logic [1:0] PH_SEC  = 2'd0;
    localparam logic [1:0] PH_MIN  = 2'd1;
    localparam logic [1:0] PH_HOUR = 2'd2;

    // Reciprocals of 15 and 6 scaled by 2^34, rounded down. The dividend is
    // shifted right by two first, so these divide by 60 and by 24.
    localparam logic [31:0] RECIP_15 = 32'd1145324612;
    localparam logic [31:0] RECIP_6  = 32'd2863311530;

    logic [1:0]  state_reg, state_next;
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] quot_reg, quot_next;
    logic [27:0] est_reg, est_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hr_reg, hr_next;

    logic [5:0]  divisor;
    logic [31:0] recip;
    logic [61:0] product;
    logic [31:0] est_wide;
    logic [31:0] est_times_div;
    logic [31:0] rem_wide;
    logic        take;
    logic [6:0]  rem_fixed;
    logic [31:0] quot_fixed;

    // Quotient estimate from the reciprocal, then remainder and correction.
    // The estimate is never high and at most one low, so one compare and
    // subtract gives the exact quotient and remainder.
    always_comb
    begin
        divisor       = (phase_reg == PH_HOUR) ? HOUR_PER_DAY
                      : ((phase_reg == PH_MIN) ? MIN_PER_HOUR : SEC_PER_MIN);
        recip         = (phase_reg == PH_HOUR) ? RECIP_6 : RECIP_15;
        product       = {32'd0, quot_reg[31:2]} * {30'd0, recip};
        est_wide      = {4'd0, est_reg};
        est_times_div = (phase_reg == PH_HOUR) ? ((est_wide << 4) + (est_wide << 3))
                                               : ((est_wide << 6) - (est_wide << 2));
        rem_wide      = quot_reg - est_times_div;
        take          = (rem_wide[6:0] >= {1'b0, divisor});
        rem_fixed     = take ? (rem_wide[6:0] - {1'b0, divisor}) : rem_wide[6:0];
        quot_fixed    = est_wide + {31'd0, take};
    end

    // Sequencer: three multiply-and-correct divisions, then hand the item
    // to the queue.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        quot_next  = quot_reg;
        est_next   = est_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    quot_next  = epoch_seconds;
                    phase_next = PH_SEC;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                est_next   = product[61:34];
                state_next = F_FIX;
            end
            F_FIX:
            begin
                quot_next = quot_fixed;
                case (phase_reg)
                    PH_SEC:
                    begin
                        sec_next   = rem_fixed[5:0];
                        phase_next = PH_MIN;
                        state_next = F_MUL;
                    end
                    PH_MIN:
                    begin
                        min_next   = rem_fixed[5:0];
                        phase_next = PH_HOUR;
                        state_next = F_MUL;
                    end
                    default:
                    begin
                        hr_next    = rem_fixed[4:0];
                        state_next = F_PUSH;
                    end
                endcase
            end
            F_PUSH:
            begin
                if (!q_status.full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= PH_SEC;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        est_reg  <= est_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hr_reg   <= hr_next;
    end

    // After the hour division the quotient holds the whole days.
    assign in_ready       = (state_reg == F_IDLE);
    assign push_valid     = (state_reg == F_PUSH);
    assign push_item.sec  = sec_reg;
    assign push_item.min  = min_reg;
    assign push_item.hr   = hr_reg;
    assign push_item.days = quot_reg[DAYS_W-1:0];

endmodule

### rtl/core/ep2cal_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar item queue
// Two-entry queue that lets the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module ep2cal_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    input  ep2cal_pkg::tod_item_t  push_item,
    input  logic                   pop_req,
    output ep2cal_pkg::tod_item_t  pop_item,
    output ep2cal_pkg::q_status_t  q_status
);
    import ep2cal_pkg::*;

    tod_item_t  entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    // Fill status and pointer updates.
    always_comb
    begin
        q_status.full  = (count_reg == 2'd2);
        q_status.empty = (count_reg == 2'd0);
        do_push        = push_valid && !q_status.full;
        do_pop         = pop_req && !q_status.empty;
        wr_ptr_next    = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next     = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item = entry_reg[rd_ptr_reg];

endmodule

### rtl/core/ep2cal_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch-to-calendar back end
// Takes whole days from the queue, subtracts years from 1970 and then months
// one per cycle, and holds the finished date and time in an output register.
// ----------------------------------------------------------------------------
module ep2cal_back (
    input  logic                   clk,
    input  logic                   rst_n,
    output logic                   pop_req,
    input  ep2cal_pkg::tod_item_t  pop_item,
    input  ep2cal_pkg::q_status_t  q_status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [5:0]             second_of_minute,
    output logic [5:0]             minute_of_hour,
    output logic [4:0]             hour_of_day,
    output logic [4:0]             day_of_month,
    output logic [3:0]             month_of_year,
    output logic [6:0]             year_of_century
);
    import ep2cal_pkg::*;

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_YEAR  = 2'd1;
    localparam logic [1:0] B_MONTH = 2'd2;
    localparam logic [1:0] B_HOLD  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    logic [DAYS_W-1:0] days_reg, days_next;
    logic [1:0]        mod4_reg, mod4_next;
    logic [6:0]        mod100_reg, mod100_next;
    logic [8:0]        mod400_reg, mod400_next;
    logic [3:0]        mon_reg, mon_next;
    tod_item_t         tod_reg, tod_next;

    logic [5:0] sec_out_reg, sec_out_next;
    logic [5:0] min_out_reg, min_out_next;
    logic [4:0] hr_out_reg, hr_out_next;
    logic [4:0] day_out_reg, day_out_next;
    logic [3:0] mon_out_reg, mon_out_next;
    logic [6:0] yr_out_reg, yr_out_next;

    logic       leap;
    logic [8:0] year_len;
    logic [4:0] mon_len;
    logic       load;
    logic       slot_free;

    // Leap rule from the running residues of the year.
    always_comb
    begin
        leap     = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
        year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
        mon_len  = month_len(mon_reg, leap);
        load     = (state_reg == B_IDLE) && !q_status.empty;
        slot_free = !out_valid_reg || out_ready;
    end

    // Year and month subtraction sequencer.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        days_next      = days_reg;
        mod4_next      = mod4_reg;
        mod100_next    = mod100_reg;
        mod400_next    = mod400_reg;
        mon_next       = mon_reg;
        tod_next       = tod_reg;
        sec_out_next   = sec_out_reg;
        min_out_next   = min_out_reg;
        hr_out_next    = hr_out_reg;
        day_out_next   = day_out_reg;
        mon_out_next   = mon_out_reg;
        yr_out_next    = yr_out_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (load)
                begin
                    tod_next    = pop_item;
                    days_next   = pop_item.days;
                    mod4_next   = EPOCH_MOD4;
                    mod100_next = EPOCH_MOD100;
                    mod400_next = EPOCH_MOD400;
                    mon_next    = MON_JAN;
                    state_next  = B_YEAR;
                end
            end
            B_YEAR:
            begin
                if (days_reg < {{(DAYS_W-9){1'b0}}, year_len})
                begin
                    state_next = B_MONTH;
                end
                else
                begin
                    days_next   = days_reg - {{(DAYS_W-9){1'b0}}, year_len};
                    mod4_next   = mod4_reg + 2'd1;
                    mod100_next = (mod100_reg == MOD100_LAST) ? 7'd0 : mod100_reg + 7'd1;
                    mod400_next = (mod400_reg == MOD400_LAST) ? 9'd0 : mod400_reg + 9'd1;
                end
            end
            B_MONTH:
            begin
                if ((mon_reg == MON_DEC) || (days_reg < {{(DAYS_W-5){1'b0}}, mon_len}))
                begin
                    state_next = B_HOLD;
                end
                else
                begin
                    days_next = days_reg - {{(DAYS_W-5){1'b0}}, mon_len};
                    mon_next  = mon_reg + 4'd1;
                end
            end
            B_HOLD:
            begin
                if (slot_free)
                begin
                    sec_out_next   = tod_reg.sec;
                    min_out_next   = tod_reg.min;
                    hr_out_next    = tod_reg.hr;
                    day_out_next   = days_reg[4:0] + 5'd1;
                    mon_out_next   = mon_reg + 4'd1;
                    yr_out_next    = mod100_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and output register.
    always_ff @(posedge clk)
    begin
        days_reg    <= days_next;
        mod4_reg    <= mod4_next;
        mod100_reg  <= mod100_next;
        mod400_reg  <= mod400_next;
        mon_reg     <= mon_next;
        tod_reg     <= tod_next;
        sec_out_reg <= sec_out_next;
        min_out_reg <= min_out_next;
        hr_out_reg  <= hr_out_next;
        day_out_reg <= day_out_next;
        mon_out_reg <= mon_out_next;
        yr_out_reg  <= yr_out_next;
    end

    assign pop_req          = (state_reg == B_IDLE);
    assign out_valid        = out_valid_reg;
    assign second_of_minute = sec_out_reg;
    assign minute_of_hour   = min_out_reg;
    assign hour_of_day      = hr_out_reg;
    assign day_of_month     = day_out_reg;
    assign month_of_year    = mon_out_reg;
    assign year_of_century  = yr_out_reg;

endmodule
